// ===== design/dbf_pkg.sv =====
// Shared types and constants for the dual byte FIFO with status.
// No dependencies; used by dbf_ctrl, dbf_datapath and the top level.
package dbf_pkg;

  // Default queue depths in entries.
  localparam int IN_DEPTH_DEF  = 1024;
  localparam int OUT_DEPTH_DEF = 1024;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IN_LOW_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH_MARGIN = 2'd1;
  localparam logic [CFG_DATA_W-1:0] LEVEL_RESET        = 12'd16;

  // Queue commands carried by an input beat.
  typedef enum logic [1:0] {
    CMD_IN_PUSH  = 2'd0,
    CMD_IN_POP   = 2'd1,
    CMD_OUT_PUSH = 2'd2,
    CMD_OUT_POP  = 2'd3
  } fifo_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_EMIT
  } ctrl_state_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic take;  // latch the accepted input beat
    logic exec;  // update queue, pointers and flags
    logic load;  // reload the top-of-queue byte from memory
    logic emit;  // move the result into the output register
  } dbf_cmd_t;

endpackage

// ===== design/dbf_ctrl.sv =====
// Sequencing state machine of the dual byte FIFO.
// Depends on dbf_pkg; drives dbf_datapath through a dbf_cmd_t strobe group.
module dbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output dbf_pkg::dbf_cmd_t cmd_str
);

  dbf_pkg::ctrl_state_t state, state_next;
  logic                 out_valid_next;
  logic                 slot_free;

  // The output register can take a result when empty or drained this cycle.
  assign slot_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dbf_pkg::ST_IDLE: begin
        if (in_valid) state_next = dbf_pkg::ST_EXEC;
      end
      dbf_pkg::ST_EXEC: state_next = dbf_pkg::ST_LOAD;
      dbf_pkg::ST_LOAD: state_next = dbf_pkg::ST_EMIT;
      dbf_pkg::ST_EMIT: begin
        if (slot_free) state_next = dbf_pkg::ST_IDLE;
      end
      default: state_next = dbf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_stall     = 1'b1;
    cmd_str      = '0;
    case (state)
      dbf_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd_str.take = in_valid;
      end
      dbf_pkg::ST_EXEC: cmd_str.exec = 1'b1;
      dbf_pkg::ST_LOAD: cmd_str.load = 1'b1;
      dbf_pkg::ST_EMIT: cmd_str.emit = slot_free;
      default: in_stall = 1'b1;
    endcase
  end

  // Output beat valid: set by an emit, cleared once the beat is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (cmd_str.emit) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dbf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/dbf_datapath.sv =====
// Queue memories, pointers, counters, status flags and result register.
// Depends on dbf_pkg; sequenced by dbf_ctrl.
module dbf_datapath #(
  parameter int IN_DEPTH  = dbf_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = dbf_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dbf_pkg::dbf_cmd_t               cmd_str,
  input  logic [1:0]                      cmd,
  input  logic [7:0]                      wr_byte,
  input  logic                            cfg_wen,
  input  logic [dbf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [7:0]                      rd_byte,
  output logic                            in_empty,
  output logic                            in_almost_empty,
  output logic                            next_valid,
  output logic                            out_full,
  output logic                            out_almost_full,
  output logic                            irq,
  output logic                            dropped
);

  localparam int IN_PTR_W  = $clog2(IN_DEPTH);
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int IN_CNT_W  = $clog2(IN_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int LVL_W     = dbf_pkg::CFG_DATA_W;
  localparam int AE_W      = (IN_CNT_W > LVL_W) ? IN_CNT_W : LVL_W;
  localparam int AF_W      = ((OUT_CNT_W > LVL_W) ? OUT_CNT_W : LVL_W) + 1;

  // Queue storage.
  logic [7:0] in_mem  [IN_DEPTH];
  logic [7:0] out_mem [OUT_DEPTH];
  logic [7:0] in_rdata, out_rdata;

  // Latched input beat.
  dbf_pkg::fifo_cmd_t cur_cmd;
  logic [7:0]         cur_byte;

  // Queue bookkeeping.
  logic [IN_PTR_W-1:0]  in_head, in_tail;
  logic [OUT_PTR_W-1:0] out_head, out_tail;
  logic [IN_CNT_W-1:0]  in_count;
  logic [OUT_CNT_W-1:0] out_count;
  logic [7:0]           in_top, out_top;
  logic                 load_in, load_out;

  // Status flags and configuration.
  logic             st_in_empty, st_in_ae, st_next_valid, st_out_full, st_out_af;
  logic [LVL_W-1:0] in_low_level, out_high_margin;

  // Pending result of the current step.
  logic [7:0] res_rd;
  logic       res_irq, res_dropped;

  // Derived values for the current step.
  logic                 in_is_full, out_is_full, in_nonempty, out_nonempty;
  logic                 in_we, out_we;
  logic [IN_CNT_W-1:0]  in_cnt_inc, in_cnt_pop;
  logic [OUT_CNT_W-1:0] out_cnt_inc, out_cnt_dec;
  logic [IN_PTR_W-1:0]  in_tail_inc, in_head_inc;
  logic [OUT_PTR_W-1:0] out_tail_inc, out_head_inc;
  logic                 in_ae_push, in_ae_pop, out_af_push, out_af_pop;

  always_comb begin
    in_is_full   = (in_count == IN_CNT_W'(IN_DEPTH));
    out_is_full  = (out_count == OUT_CNT_W'(OUT_DEPTH));
    in_nonempty  = (in_count != '0);
    out_nonempty = (out_count != '0);
    in_cnt_inc   = in_count + IN_CNT_W'(1);
    in_cnt_pop   = in_nonempty ? in_count - IN_CNT_W'(1) : in_count;
    out_cnt_inc  = out_count + OUT_CNT_W'(1);
    out_cnt_dec  = out_count - OUT_CNT_W'(1);
    in_tail_inc  = (in_tail == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : in_tail + IN_PTR_W'(1);
    in_head_inc  = (in_head == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : in_head + IN_PTR_W'(1);
    out_tail_inc = (out_tail == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                 : out_tail + OUT_PTR_W'(1);
    out_head_inc = (out_head == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                 : out_head + OUT_PTR_W'(1);
    in_ae_push   = AE_W'(in_cnt_inc) <= AE_W'(in_low_level);
    in_ae_pop    = AE_W'(in_cnt_pop) <= AE_W'(in_low_level);
    out_af_push  = (AF_W'(out_cnt_inc) + AF_W'(out_high_margin)) >= AF_W'(OUT_DEPTH);
    out_af_pop   = (AF_W'(out_cnt_dec) + AF_W'(out_high_margin)) >= AF_W'(OUT_DEPTH);
    in_we        = cmd_str.exec && (cur_cmd == dbf_pkg::CMD_IN_PUSH) && !in_is_full;
    out_we       = cmd_str.exec && (cur_cmd == dbf_pkg::CMD_OUT_PUSH) && !out_is_full;
  end

  // Memories: one write at the tail, a registered read at the head.
  always_ff @(posedge clk) begin
    if (in_we) in_mem[in_tail] <= cur_byte;
    in_rdata <= in_mem[in_head];
  end

  always_ff @(posedge clk) begin
    if (out_we) out_mem[out_tail] <= cur_byte;
    out_rdata <= out_mem[out_head];
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd_str.take) begin
      cur_cmd  <= dbf_pkg::fifo_cmd_t'(cmd);
      cur_byte <= wr_byte;
    end
  end

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_low_level    <= dbf_pkg::LEVEL_RESET;
      out_high_margin <= dbf_pkg::LEVEL_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        dbf_pkg::REG_IN_LOW_LEVEL:    in_low_level    <= cfg_data;
        dbf_pkg::REG_OUT_HIGH_MARGIN: out_high_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // Queue step: pointers, counts, flags and the pending result.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_head       <= '0;
      in_tail       <= '0;
      in_count      <= '0;
      out_head      <= '0;
      out_tail      <= '0;
      out_count     <= '0;
      in_top        <= '0;
      out_top       <= '0;
      load_in       <= 1'b0;
      load_out      <= 1'b0;
      st_in_empty   <= 1'b1;
      st_in_ae      <= 1'b1;
      st_next_valid <= 1'b0;
      st_out_full   <= 1'b0;
      st_out_af     <= 1'b0;
      res_rd        <= '0;
      res_irq       <= 1'b0;
      res_dropped   <= 1'b0;
    end else if (cmd_str.exec) begin
      res_rd      <= '0;
      res_irq     <= 1'b0;
      res_dropped <= 1'b0;
      load_in     <= 1'b0;
      load_out    <= 1'b0;
      case (cur_cmd)
        dbf_pkg::CMD_IN_PUSH: begin
          if (in_is_full) begin
            res_dropped <= 1'b1;
          end else begin
            in_tail     <= in_tail_inc;
            in_count    <= in_cnt_inc;
            st_in_ae    <= in_ae_push;
            st_in_empty <= 1'b0;
          end
        end
        dbf_pkg::CMD_IN_POP: begin
          res_rd        <= in_top;
          st_next_valid <= in_nonempty;
          load_in       <= in_nonempty;
          if (in_nonempty) begin
            in_count <= in_cnt_pop;
            if (in_cnt_pop == '0) begin
              in_head <= '0;
              in_tail <= '0;
            end else begin
              in_head <= in_head_inc;
            end
          end
          // Almost-empty is raised by a pop only on its first crossing.
          if (in_ae_pop && !st_in_ae) begin
            st_in_ae <= 1'b1;
            res_irq  <= 1'b1;
          end
          st_in_empty <= (in_cnt_pop == '0);
        end
        dbf_pkg::CMD_OUT_PUSH: begin
          if (out_is_full) begin
            res_dropped <= 1'b1;
          end else begin
            out_tail  <= out_tail_inc;
            out_count <= out_cnt_inc;
            if ((out_af_push && !st_out_af) || (out_cnt_inc == OUT_CNT_W'(OUT_DEPTH))) begin
              res_irq <= 1'b1;
            end
            if (out_af_push) st_out_af <= 1'b1;
            if (out_cnt_inc == OUT_CNT_W'(OUT_DEPTH)) st_out_full <= 1'b1;
          end
        end
        dbf_pkg::CMD_OUT_POP: begin
          res_rd <= out_top;
          if (out_nonempty) begin
            load_out    <= 1'b1;
            out_count   <= out_cnt_dec;
            st_out_af   <= out_af_pop;
            st_out_full <= 1'b0;
            if (out_cnt_dec == '0) begin
              out_head <= '0;
              out_tail <= '0;
            end else begin
              out_head <= out_head_inc;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_str.load) begin
      // Read data was captured at the head as it stood before the pop.
      if (load_in) in_top <= in_rdata;
      if (load_out) out_top <= out_rdata;
    end
  end

  // Output register: the flags as they stand after the step.
  always_ff @(posedge clk) begin
    if (cmd_str.emit) begin
      rd_byte         <= res_rd;
      in_empty        <= st_in_empty;
      in_almost_empty <= st_in_ae;
      next_valid      <= st_next_valid;
      out_full        <= st_out_full;
      out_almost_full <= st_out_af;
      irq             <= res_irq;
      dropped         <= res_dropped;
    end
  end

endmodule

// ===== design/dual_byte_fifo_with_status_unit.sv =====
// Dual byte FIFO with status: input and output byte queues with top-byte registers.
// Each input beat passes through accept, queue update, head memory read reload and
// output load in that order; a new beat is accepted only once the last result has
// been loaded, and the output load waits while the output side is stalled.
// Reset clears pointers, counts and top bytes, sets empty and almost-empty and
// restores both thresholds to 16; queue memories are not cleared.
module dual_byte_fifo_with_status_unit #(
  parameter int IN_DEPTH  = dbf_pkg::IN_DEPTH_DEF,
  parameter int OUT_DEPTH = dbf_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [7:0]                     wr_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     rd_byte,
  output logic                           in_empty,
  output logic                           in_almost_empty,
  output logic                           next_valid,
  output logic                           out_full,
  output logic                           out_almost_full,
  output logic                           irq,
  output logic                           dropped,
  input  logic                           cfg_wen,
  input  logic [dbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbf_pkg::CFG_DATA_W-1:0] cfg_data
);

  dbf_pkg::dbf_cmd_t cmd_str;

  // Sequencer.
  dbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_str   (cmd_str)
  );

  // Queues, flags and result register.
  dbf_datapath #(
    .IN_DEPTH  (IN_DEPTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd_str         (cmd_str),
    .cmd             (cmd),
    .wr_byte         (wr_byte),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rd_byte         (rd_byte),
    .in_empty        (in_empty),
    .in_almost_empty (in_almost_empty),
    .next_valid      (next_valid),
    .out_full        (out_full),
    .out_almost_full (out_almost_full),
    .irq             (irq),
    .dropped         (dropped)
  );

endmodule
